FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: sv/exl_pkg.sv
// ----------------------------------------------------------------------------
// exl_pkg
// Token codes, token record and queue constants for the expression lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package exl_pkg;

    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_PLUS    = 5'd1;
    localparam logic [4:0] K_MINUS   = 5'd2;
    localparam logic [4:0] K_DIV     = 5'd3;
    localparam logic [4:0] K_MUL     = 5'd4;
    localparam logic [4:0] K_NUMBER  = 5'd5;
    localparam logic [4:0] K_IDENT   = 5'd6;
    localparam logic [4:0] K_ASSIGN  = 5'd7;
    localparam logic [4:0] K_EQ      = 5'd8;
    localparam logic [4:0] K_LT      = 5'd9;
    localparam logic [4:0] K_LE      = 5'd10;
    localparam logic [4:0] K_GT      = 5'd11;
    localparam logic [4:0] K_GE      = 5'd12;
    localparam logic [4:0] K_IF      = 5'd13;
    localparam logic [4:0] K_FOR     = 5'd14;
    localparam logic [4:0] K_WHILE   = 5'd15;
    localparam logic [4:0] K_PRINT   = 5'd16;
    localparam logic [4:0] K_UNKNOWN = 5'd17;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;
    localparam int unsigned Q_LW    = 3;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] start;
        logic [7:0]  len;
        logic        last;
    } t_tok;

    typedef struct packed {
        logic [1:0] n;
        t_tok       t0;
        t_tok       t1;
    } t_push;

    typedef struct packed {
        logic            space2;
        logic [Q_LW-1:0] level;
    } t_q_stat;

endpackage

`default_nettype wire

FILE: sv/exl_scan.sv
// ----------------------------------------------------------------------------
// exl_scan
// Scanner state machine: one character step per accepted item, up to two
// tokens pushed to the output queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module exl_scan
    import exl_pkg::*;
#(
    parameter int unsigned LEN_MAX = 255
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_accept,
    input  wire [7:0]  i_ch,
    input  wire        i_eoi,
    output t_push      o_push
);

    localparam logic [7:0] LenCap = 8'((LEN_MAX < 255) ? LEN_MAX : 255);

    typedef enum logic [2:0] {
        M_START, M_NUMBER, M_ID, M_IDLONG, M_EQUAL, M_LESS, M_GREATER, M_COMMENT
    } t_mode;

    typedef struct packed {
        logic       emit;
        logic [4:0] kind;
        logic       beg;
        logic       kw0;
        t_mode      mode;
    } t_sp;

    t_mode       r_mode, n_mode;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_start, n_start;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_kw [5];
    logic        kw_we;
    logic [2:0]  kw_idx;
    logic        do_start;
    logic        pre_emit;
    t_tok        pre_tok;
    t_sp         sp;
    t_push       push;
    logic [4:0]  one_kind;

    function automatic logic f_digit(input logic [7:0] c);
        f_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic f_alpha(input logic [7:0] c);
        f_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
                  || (c == 8'h5F);
    endfunction

    function automatic logic f_space(input logic [7:0] c);
        f_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [7:0] f_sat_inc(input logic [7:0] len);
        f_sat_inc = (len < LenCap) ? len + 8'd1 : LenCap;
    endfunction

    function automatic t_sp f_start(input logic [7:0] c, input logic eoi);
        t_sp s;
        s = '{emit: 1'b0, kind: K_UNKNOWN, beg: 1'b0, kw0: 1'b0, mode: M_START};
        priority if (eoi) begin
            s.emit = 1'b1; s.kind = K_EOF;
        end else if (f_digit(c)) begin
            s.beg = 1'b1; s.mode = M_NUMBER;
        end else if (f_alpha(c)) begin
            s.beg = 1'b1; s.kw0 = 1'b1; s.mode = M_ID;
        end else if (c == 8'h3D) begin
            s.beg = 1'b1; s.mode = M_EQUAL;
        end else if (c == 8'h3C) begin
            s.beg = 1'b1; s.mode = M_LESS;
        end else if (c == 8'h3E) begin
            s.beg = 1'b1; s.mode = M_GREATER;
        end else if (f_space(c)) begin
            s.mode = M_START;
        end else if (c == 8'h23) begin
            s.mode = M_COMMENT;
        end else if (c == 8'h2B) begin
            s.emit = 1'b1; s.kind = K_PLUS;
        end else if (c == 8'h2D) begin
            s.emit = 1'b1; s.kind = K_MINUS;
        end else if (c == 8'h2F) begin
            s.emit = 1'b1; s.kind = K_DIV;
        end else if (c == 8'h2A) begin
            s.emit = 1'b1; s.kind = K_MUL;
        end else begin
            s.emit = 1'b1; s.kind = K_UNKNOWN;
        end
        f_start = s;
    endfunction

    function automatic logic [4:0] f_ident_kind(
        input logic [7:0] len, input logic [7:0] k0, input logic [7:0] k1,
        input logic [7:0] k2, input logic [7:0] k3, input logic [7:0] k4);
        priority if (len == 8'd2 && k0 == 8'h69 && k1 == 8'h66) begin
            f_ident_kind = K_IF;
        end else if (len == 8'd3 && k0 == 8'h66 && k1 == 8'h6F && k2 == 8'h72) begin
            f_ident_kind = K_FOR;
        end else if (len == 8'd5 && k0 == 8'h77 && k1 == 8'h68 && k2 == 8'h69
                     && k3 == 8'h6C && k4 == 8'h65) begin
            f_ident_kind = K_WHILE;
        end else if (len == 8'd5 && k0 == 8'h70 && k1 == 8'h72 && k2 == 8'h69
                     && k3 == 8'h6E && k4 == 8'h74) begin
            f_ident_kind = K_PRINT;
        end else begin
            f_ident_kind = K_IDENT;
        end
    endfunction

    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_len    = r_len;
        n_pos    = i_eoi ? r_pos : r_pos + 32'd1;
        kw_we    = 1'b0;
        kw_idx   = 3'd0;
        do_start = 1'b0;
        pre_emit = 1'b0;
        pre_tok  = '{kind: K_EOF, start: r_start, len: r_len, last: 1'b0};
        one_kind = K_ASSIGN;
        if (r_mode == M_LESS) begin
            one_kind = K_LT;
        end else if (r_mode == M_GREATER) begin
            one_kind = K_GT;
        end

        unique case (r_mode)
            M_START: begin
                do_start = 1'b1;
            end
            M_NUMBER: begin
                if (!i_eoi && f_digit(i_ch)) begin
                    n_len = f_sat_inc(r_len);
                end else begin
                    pre_emit     = 1'b1;
                    pre_tok.kind = K_NUMBER;
                    do_start     = 1'b1;
                end
            end
            M_ID, M_IDLONG: begin
                if (!i_eoi && (f_alpha(i_ch) || f_digit(i_ch))) begin
                    if (r_mode == M_ID && r_len < 8'd5) begin
                        kw_we  = 1'b1;
                        kw_idx = r_len[2:0];
                        n_len  = r_len + 8'd1;
                    end else begin
                        n_mode = M_IDLONG;
                        n_len  = f_sat_inc(r_len);
                    end
                end else begin
                    pre_emit     = 1'b1;
                    pre_tok.kind = (r_mode == M_ID)
                        ? f_ident_kind(r_len, r_kw[0], r_kw[1], r_kw[2], r_kw[3], r_kw[4])
                        : K_IDENT;
                    do_start     = 1'b1;
                end
            end
            M_EQUAL, M_LESS, M_GREATER: begin
                pre_emit = 1'b1;
                if (!i_eoi && i_ch == 8'h3D) begin
                    pre_tok.kind = one_kind + 5'd1;
                    pre_tok.len  = 8'd2;
                    n_mode       = M_START;
                end else begin
                    pre_tok.kind = one_kind;
                    pre_tok.len  = 8'd1;
                    do_start     = 1'b1;
                end
            end
            M_COMMENT: begin
                if (i_eoi) begin
                    pre_emit      = 1'b1;
                    pre_tok.kind  = K_EOF;
                    pre_tok.start = r_pos;
                    pre_tok.len   = 8'd0;
                    n_mode        = M_START;
                end else if (i_ch == 8'h23) begin
                    n_mode = M_START;
                end
            end
            default: begin
                n_mode = M_START;
            end
        endcase

        sp = f_start(i_ch, i_eoi);
        push.n  = {1'b0, pre_emit};
        push.t0 = pre_tok;
        push.t1 = '{kind: sp.kind, start: r_pos, len: (sp.kind == K_EOF) ? 8'd0 : 8'd1,
                    last: 1'b0};
        if (do_start) begin
            n_mode = sp.mode;
            if (sp.beg) begin
                n_start = r_pos;
                n_len   = 8'd1;
            end
            if (sp.kw0) begin
                kw_we  = 1'b1;
                kw_idx = 3'd0;
            end
            if (sp.emit) begin
                if (pre_emit) begin
                    push.n = 2'd2;
                end else begin
                    push.n  = 2'd1;
                    push.t0 = push.t1;
                end
            end
        end
        push.t0.last = (push.n == 2'd1);
        push.t1.last = 1'b1;
        if (!i_accept) begin
            push.n = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_START;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && kw_we) begin
            r_kw[kw_idx] <= i_ch;
        end
    end

endmodule

`default_nettype wire

FILE: sv/exl_outq.sv
// ----------------------------------------------------------------------------
// exl_outq
// Four-entry token queue: takes up to two tokens per cycle, sends one per pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module exl_outq
    import exl_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_push   i_push,
    input  wire     i_pop,
    output t_tok    o_head,
    output logic    o_valid,
    output t_q_stat o_stat
);

    t_tok            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_LW-1:0] r_level;
    logic            pop;
    logic [Q_AW-1:0] wp1;

    assign o_valid = (r_level != '0);
    assign pop     = i_pop && o_valid;
    assign o_head  = r_mem[r_rp];
    assign wp1     = r_wp + Q_AW'(1);
    assign o_stat.level  = r_level;
    assign o_stat.space2 = (r_level <= Q_LW'(Q_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= r_wp + i_push.n;
            r_rp    <= r_rp + Q_AW'(pop);
            r_level <= r_level + Q_LW'(i_push.n) - Q_LW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.t0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wp1] <= i_push.t1;
        end
    end

endmodule

`default_nettype wire

FILE: sv/expression_lexer_fsm_top.sv
// ----------------------------------------------------------------------------
// expression_lexer_fsm_top
// Character-stream lexer: one byte per item in, tokens out.
// ----------------------------------------------------------------------------
// It takes one character per cycle while at least two queue entries are free
// and updates the scanner state in the cycle an item is accepted, when its
// tokens also enter the output queue. An item yields zero, one or two tokens
// (two when a lookahead character both ends a token and forms one itself);
// tokens go through a four-entry queue that drains one per cycle while the
// sink is ready, so with a ready sink a stream that averages at most one
// token per character runs at one item per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module expression_lexer_fsm_top
    import exl_pkg::*;
#(
    parameter int unsigned LEN_MAX = 255
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  wire         i_s_axis_tuser,   // [0] end_of_input
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] token_start, [39:32] token_length
    output logic [4:0]  o_m_axis_tuser,   // [4:0] token_kind
    output logic        o_m_axis_tlast
);

    t_push   push;
    t_tok    head;
    t_q_stat stat;
    logic    s_acc;

    assign o_s_axis_tready = stat.space2;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    exl_scan #(
        .LEN_MAX (LEN_MAX)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_acc),
        .i_ch     (i_s_axis_tdata),
        .i_eoi    (i_s_axis_tuser),
        .o_push   (push)
    );

    exl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_axis_tready),
        .o_head  (head),
        .o_valid (o_m_axis_tvalid),
        .o_stat  (stat)
    );

    assign o_m_axis_tdata = {head.len, head.start};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

    `ASSERT_NEVER(a_q_over, i_clk, i_rst_n, stat.level > Q_LW'(Q_DEPTH), "queue overflow")
    `ASSERT_PROP(a_push_acc, i_clk, i_rst_n, (push.n != 2'd0) |-> s_acc, "push without item")
    `ASSERT_PROP(a_push_out, i_clk, i_rst_n, (push.n != 2'd0) |=> o_m_axis_tvalid, "token lost")
    `ASSERT_NEVER(a_kind, i_clk, i_rst_n, o_m_axis_tvalid && (head.kind > K_UNKNOWN), "bad kind")

endmodule

`default_nettype wire

FILE: tb/tb_expression_lexer_fsm_top.sv
// ----------------------------------------------------------------------------
// tb_expression_lexer_fsm_top
// Drives character streams into the lexer and checks every token it emits
// against an in-bench scanner model: directed operators and special cases,
// saturating long tokens, then random lexeme sequences with bursty input and
// a stalling token sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_expression_lexer_fsm_top;
    import exl_pkg::*;

    localparam int LEN_MAX      = 255;
    localparam int LEN_CAP      = (LEN_MAX < 255) ? LEN_MAX : 255;
    localparam int N_ITEMS      = 1250;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [2:0] {
        SC_START, SC_NUMBER, SC_IDENT, SC_IDLONG,
        SC_EQUAL, SC_LESS, SC_GREATER, SC_COMMENT
    } scan_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    // scanner model state
    scan_e       sc_mode = SC_START;
    logic [31:0] sc_pos = 32'd0;
    logic [31:0] sc_start = 32'd0;
    logic [7:0]  sc_len = 8'd0;
    logic [7:0]  kw_buf [0:4];

    t_tok        tok_expect [$];
    t_tok        tok_want;
    int          n_fail = 0;
    int          items_sent = 0;
    int          tokens_checked = 0;
    int          burst_left = 0;
    int          rdy_hold = 0;
    int          idle_cycles = 0;

    string       word_list [10] = '{"if", "for", "while", "print", "iff",
                                    "fo", "whilst", "printf", "prinT", "x_1"};
    string       op_list [10] = '{"+", "-", "/", "*", "=", "==", "<", "<=",
                                  ">", ">="};

    expression_lexer_fsm_top #(
        .LEN_MAX(LEN_MAX)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] ch
        .i_s_axis_tuser  (s_tuser),   // [0] end_of_input
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [31:0] token_start, [39:32] token_length
        .o_m_axis_tuser  (m_tuser),   // [4:0] token_kind
        .o_m_axis_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [7:0] sat_inc(logic [7:0] len);
        return (len < LEN_CAP) ? len + 8'd1 : 8'(LEN_CAP);
    endfunction

    function automatic t_tok mk_tok(logic [4:0] kind, logic [31:0] start, logic [7:0] len);
        t_tok t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic void open_token(scan_e m, logic [31:0] p);
        sc_mode  = m;
        sc_start = p;
        sc_len   = 8'd1;
    endfunction

    // Advance the scanner by one item and queue the tokens it yields.
    task automatic lex_step(input logic [7:0] c, input logic eoi);
        t_tok        toks [$];
        logic [31:0] pos;
        logic        again;
        logic [4:0]  kind;
        logic [4:0]  rel_one;
        logic [4:0]  rel_two;
        pos   = sc_pos;
        again = 1'b1;
        for (int pass = 0; pass < 2 && again; pass++) begin
            again = 1'b0;
            case (sc_mode)
                SC_START: begin
                    if (eoi) toks.push_back(mk_tok(K_EOF, pos, 8'd0));
                    else if (is_digit(c)) open_token(SC_NUMBER, pos);
                    else if (is_alpha(c)) begin
                        open_token(SC_IDENT, pos);
                        kw_buf[0] = c;
                    end
                    else if (c == "=") open_token(SC_EQUAL, pos);
                    else if (c == "<") open_token(SC_LESS, pos);
                    else if (c == ">") open_token(SC_GREATER, pos);
                    else if (c == " " || c == 8'd9 || c == 8'd10 || c == 8'd11 ||
                             c == 8'd12 || c == 8'd13) begin
                    end
                    else if (c == "#") sc_mode = SC_COMMENT;
                    else if (c == "+") toks.push_back(mk_tok(K_PLUS, pos, 8'd1));
                    else if (c == "-") toks.push_back(mk_tok(K_MINUS, pos, 8'd1));
                    else if (c == "/") toks.push_back(mk_tok(K_DIV, pos, 8'd1));
                    else if (c == "*") toks.push_back(mk_tok(K_MUL, pos, 8'd1));
                    else toks.push_back(mk_tok(K_UNKNOWN, pos, 8'd1));
                end
                SC_NUMBER: begin
                    if (!eoi && is_digit(c)) sc_len = sat_inc(sc_len);
                    else begin
                        toks.push_back(mk_tok(K_NUMBER, sc_start, sc_len));
                        sc_mode = SC_START;
                        again   = 1'b1;
                    end
                end
                SC_IDENT, SC_IDLONG: begin
                    if (!eoi && (is_alpha(c) || is_digit(c))) begin
                        if (sc_mode == SC_IDENT && sc_len < 5) begin
                            kw_buf[sc_len] = c;
                            sc_len = sc_len + 8'd1;
                        end else begin
                            sc_mode = SC_IDLONG;
                            sc_len  = sat_inc(sc_len);
                        end
                    end else begin
                        kind = K_IDENT;
                        if (sc_mode == SC_IDENT) begin
                            if (sc_len == 2 && {kw_buf[0], kw_buf[1]} == "if")
                                kind = K_IF;
                            else if (sc_len == 3 && {kw_buf[0], kw_buf[1], kw_buf[2]} == "for")
                                kind = K_FOR;
                            else if (sc_len == 5 && {kw_buf[0], kw_buf[1], kw_buf[2],
                                                     kw_buf[3], kw_buf[4]} == "while")
                                kind = K_WHILE;
                            else if (sc_len == 5 && {kw_buf[0], kw_buf[1], kw_buf[2],
                                                     kw_buf[3], kw_buf[4]} == "print")
                                kind = K_PRINT;
                        end
                        toks.push_back(mk_tok(kind, sc_start, sc_len));
                        sc_mode = SC_START;
                        again   = 1'b1;
                    end
                end
                SC_EQUAL, SC_LESS, SC_GREATER: begin
                    if (sc_mode == SC_EQUAL) begin
                        rel_one = K_ASSIGN;
                        rel_two = K_EQ;
                    end else if (sc_mode == SC_LESS) begin
                        rel_one = K_LT;
                        rel_two = K_LE;
                    end else begin
                        rel_one = K_GT;
                        rel_two = K_GE;
                    end
                    if (!eoi && c == "=")
                        toks.push_back(mk_tok(rel_two, sc_start,
                                              8'((LEN_CAP < 2) ? LEN_CAP : 2)));
                    else begin
                        toks.push_back(mk_tok(rel_one, sc_start, 8'd1));
                        again = 1'b1;
                    end
                    sc_mode = SC_START;
                end
                default: begin
                    if (eoi) begin
                        toks.push_back(mk_tok(K_EOF, pos, 8'd0));
                        sc_mode = SC_START;
                    end else if (c == "#") sc_mode = SC_START;
                end
            endcase
        end
        if (toks.size() > 0) toks[toks.size() - 1].last = 1'b1;
        foreach (toks[i]) tok_expect.push_back(toks[i]);
        if (!eoi) sc_pos = pos + 32'd1;
    endtask

    // Send one item; open a new burst with a random gap when the last one ends.
    task automatic send_char(input logic [7:0] c, input logic eoi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eoi;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        lex_step(c, eoi);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
    endtask

    task automatic send_eof();
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Hold input until every expected token has arrived.
    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (tok_expect.size() > 0);
    endtask

    function automatic logic [7:0] ident_char(bit allow_digit);
        int r;
        r = $urandom_range(0, allow_digit ? 62 : 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return "_";
        return 8'("0" + r - 53);
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 5))
            0: return " ";
            1: return 8'd9;
            2: return 8'd10;
            3: return 8'd11;
            4: return 8'd12;
            default: return 8'd13;
        endcase
    endfunction

    task automatic test_directed();
        send_text("1+-/*\t<=<>=>x==if##");
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_text("ab");
        send_char(8'hFF, 1'b1);
        send_char("#", 1'b1);
        send_text("#z");
        send_eof();
    endtask

    task automatic test_long_tokens();
        repeat (300) send_char(8'("0" + $urandom_range(0, 9)), 1'b0);
        send_text("+while");
        repeat (300) send_char(ident_char(1'b1), 1'b0);
        send_char(" ", 1'b0);
        send_text("print");
        repeat (260) send_char(ident_char(1'b1), 1'b0);
        send_eof();
    endtask

    task automatic test_random_stream(input int n_target);
        int pick;
        logic [7:0] b;
        while (items_sent < n_target) begin
            pick = $urandom_range(0, 99);
            if (items_sent > n_target / 2 && items_sent < n_target / 2 + 8) wait_drained();
            if (pick < 20) begin
                repeat ($urandom_range(1, 6)) send_char(8'("0" + $urandom_range(0, 9)), 1'b0);
            end else if (pick < 45) begin
                if ($urandom_range(0, 1)) send_text(word_list[$urandom_range(0, 9)]);
                else begin
                    send_char(ident_char(1'b0), 1'b0);
                    repeat ($urandom_range(0, 7)) send_char(ident_char(1'b1), 1'b0);
                end
            end else if (pick < 70) begin
                send_text(op_list[$urandom_range(0, 9)]);
            end else if (pick < 80) begin
                send_char("#", 1'b0);
                repeat ($urandom_range(0, 6)) begin
                    b = 8'($urandom_range(0, 255));
                    send_char((b == "#") ? 8'h23 ^ 8'h01 : b, 1'b0);
                end
                if ($urandom_range(0, 7) != 0) send_char("#", 1'b0);
            end else if (pick < 90) begin
                send_char(space_char(), 1'b0);
            end else if (pick < 97) begin
                send_char(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                send_eof();
            end
            if ($urandom_range(0, 1)) send_char(space_char(), 1'b0);
        end
    endtask

    // token sink: long ready stretches, stall runs and random toggling
    always @(posedge clk) begin
        if (rdy_hold == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    m_tready <= 1'b1;
                    rdy_hold <= $urandom_range(20, 80);
                end
                1: begin
                    m_tready <= 1'b0;
                    rdy_hold <= $urandom_range(1, 12);
                end
                default: begin
                    m_tready <= 1'($urandom_range(0, 1));
                    rdy_hold <= $urandom_range(1, 3);
                end
            endcase
        end else begin
            rdy_hold <= rdy_hold - 1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (tok_expect.size() == 0) begin
                $error("token with no expectation: kind %0d start %0d length %0d",
                       m_tuser, m_tdata[31:0], m_tdata[39:32]);
                n_fail++;
            end else begin
                tok_want = tok_expect.pop_front();
                tokens_checked++;
                if (m_tuser !== tok_want.kind) begin
                    $error("token_kind mismatch: expected %0d, actual %0d",
                           tok_want.kind, m_tuser);
                    n_fail++;
                end
                if (m_tdata[31:0] !== tok_want.start) begin
                    $error("token_start mismatch: expected %0d, actual %0d",
                           tok_want.start, m_tdata[31:0]);
                    n_fail++;
                end
                if (m_tdata[39:32] !== tok_want.len) begin
                    $error("token_length mismatch: expected %0d, actual %0d",
                           tok_want.len, m_tdata[39:32]);
                    n_fail++;
                end
                if (m_tlast !== tok_want.last) begin
                    $error("last mismatch: expected %0d, actual %0d",
                           tok_want.last, m_tlast);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (!s_tvalid && tok_expect.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("expression_lexer_fsm_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        kw_buf = '{default: 8'd0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        wait_drained();
        test_long_tokens();
        wait_drained();
        test_random_stream(N_ITEMS);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d characters and end marks, %0d tokens compared:",
                 items_sent, tokens_checked);
        $display("operators, keywords, comments, saturating tokens, random lexemes");
        if (n_fail == 0) begin
            $display("expression_lexer_fsm_top verification clean");
        end else begin
            $display("expression_lexer_fsm_top verification failed");
        end
        $finish;
    end

endmodule
